FILE: src/fcsr_pkg.sv
// Package for the filled-circle span rasterizer.
// Holds the word kinds, command and register codes, and the config and burst structs.
// No dependencies.
package fcsr_pkg;

   localparam int XW     = 8;
   localparam int YW     = 9;
   localparam int COLORW = 16;
   localparam int DISPW  = 2;
   localparam int KINDW  = 3;
   localparam int VALW   = 16;
   localparam int IDXW   = 3;

   // word kinds
   localparam logic [KINDW-1:0] KIND_PAGE   = 3'd0;
   localparam logic [KINDW-1:0] KIND_COLUMN = 3'd1;
   localparam logic [KINDW-1:0] KIND_CMD    = 3'd2;
   localparam logic [KINDW-1:0] KIND_PIXEL  = 3'd3;
   localparam logic [KINDW-1:0] KIND_END    = 3'd4;

   // memory-write command byte
   localparam logic [VALW-1:0] CMD_MEM_WRITE = 16'h002c;

   // register indexes
   localparam logic [IDXW-1:0] REG_X_BEGIN  = 3'd0;
   localparam logic [IDXW-1:0] REG_X_END    = 3'd1;
   localparam logic [IDXW-1:0] REG_Y_BEGIN  = 3'd2;
   localparam logic [IDXW-1:0] REG_Y_END    = 3'd3;
   localparam logic [IDXW-1:0] REG_COLOR    = 3'd4;
   localparam logic [IDXW-1:0] REG_DISPLAY  = 3'd5;

   typedef struct packed {
      logic [XW-1:0]     x_begin;
      logic [XW-1:0]     x_end;
      logic [YW-1:0]     y_begin;
      logic [YW-1:0]     y_end;
      logic [COLORW-1:0] fill_color;
      logic [DISPW-1:0]  display_select;
   } cfg_type;

   // one tick's worth of output words, handed from walker to emitter
   typedef struct packed {
      logic              load;
      logic [KINDW-1:0]  kind;
      logic [VALW-1:0]   row;
      logic [VALW-1:0]   col;
      logic [YW-1:0]     y_end;
      logic [XW-1:0]     x_end;
      logic [COLORW-1:0] color;
      logic [DISPW-1:0]  disp;
   } burst_type;

endpackage

FILE: src/fcsr_inside.sv
// Circle membership test for one grid cell: three squares, a sum and a compare.
// Depends on fcsr_pkg for the config struct.
module fcsr_inside #(
   parameter int COORD_WIDTH = 9
) (
   input  fcsr_pkg::cfg_type         cfg,
   input  logic [COORD_WIDTH-1:0]    col,
   input  logic [COORD_WIDTH-1:0]    row,
   output logic                      in_circle
);

   localparam int DW = COORD_WIDTH + 3;

   logic                 narrow;
   logic                 col_out;
   logic [7:0]           diff;
   logic [6:0]           radius;
   logic [8:0]           cx;
   logic [9:0]           cy;
   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;
   logic signed [2*DW-1:0] dxw;
   logic signed [2*DW-1:0] dyw;
   logic [2*DW-1:0]      dx2;
   logic [2*DW-1:0]      dy2;
   logic [2*DW:0]        dist_sq;
   logic [13:0]          rr;

   assign narrow  = {1'b0, cfg.x_end} < ({1'b0, cfg.x_begin} + 9'd2);
   assign col_out = col >= COORD_WIDTH'(cfg.x_end);

   // radius is only meaningful when the box is at least two wide
   assign diff   = cfg.x_end - cfg.x_begin;
   assign radius = diff[7:1] - 7'd1;
   assign cx     = {1'b0, cfg.x_begin} + 9'(radius);
   assign cy     = {1'b0, cfg.y_begin} + 10'(radius);

   assign dx  = $signed(DW'(col)) - $signed(DW'(cx));
   assign dy  = $signed(DW'(row)) - $signed(DW'(cy));
   assign dxw = {{DW{dx[DW-1]}}, dx};
   assign dyw = {{DW{dy[DW-1]}}, dy};
   assign dx2 = $unsigned(dxw * dxw);
   assign dy2 = $unsigned(dyw * dyw);
   assign dist_sq = {1'b0, dx2} + {1'b0, dy2};
   assign rr   = radius * radius;

   assign in_circle = !narrow && !col_out && (dist_sq <= (2*DW+1)'(rr));

endmodule

FILE: src/fcsr_walker.sv
// Walk state for the rasterizer: position, open span and active flag.
// Decides per tick which words to emit. Depends on fcsr_pkg and fcsr_inside.
module fcsr_walker #(
   parameter int COORD_WIDTH = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  fcsr_pkg::cfg_type   cfg,
   input  logic                take,
   input  logic                start_req,
   output fcsr_pkg::burst_type burst
);

   localparam int CMPW = COORD_WIDTH + 2;

   logic [COORD_WIDTH-1:0] col_ff, col_in;
   logic [COORD_WIDTH-1:0] row_ff, row_in;
   logic                   open_ff, open_in;
   logic                   active_ff, active_in;

   logic                   in_circle;
   logic                   narrow;
   logic                   no_rows;
   logic                   done;
   logic                   col_last;
   logic [8:0]             xb1;
   logic [COORD_WIDTH-1:0] col_start;
   logic [COORD_WIDTH-1:0] row_next;

   function automatic logic [fcsr_pkg::VALW-1:0] VALW_CAST(input logic [COORD_WIDTH-1:0] v);
      VALW_CAST = fcsr_pkg::VALW'(v);
   endfunction

   fcsr_inside #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_inside (
      .cfg      (cfg),
      .col      (col_ff),
      .row      (row_ff),
      .in_circle(in_circle)
   );

   assign narrow    = {1'b0, cfg.x_end} < ({1'b0, cfg.x_begin} + 9'd2);
   assign no_rows   = {1'b0, cfg.y_end} <= ({1'b0, cfg.y_begin} + 10'd1);
   assign xb1       = {1'b0, cfg.x_begin} + 9'd1;
   assign col_start = COORD_WIDTH'(xb1);
   assign row_next  = row_ff + COORD_WIDTH'(1);
   assign done      = CMPW'(row_ff) >= CMPW'(cfg.y_end);
   assign col_last  = (CMPW'(col_ff) + CMPW'(1)) >= CMPW'(cfg.x_end);

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      open_in   = open_ff;
      active_in = active_ff;

      burst       = '0;
      burst.row   = VALW_CAST(row_ff);
      burst.col   = VALW_CAST(col_ff);
      burst.y_end = cfg.y_end;
      burst.x_end = cfg.x_end;
      burst.color = cfg.fill_color;
      burst.disp  = cfg.display_select;
      burst.kind  = fcsr_pkg::KIND_PIXEL;

      if (start_req) begin
         col_in    = col_start;
         row_in    = (narrow || no_rows) ? COORD_WIDTH'(cfg.y_end)
                                         : COORD_WIDTH'({1'b0, cfg.y_begin} + 10'd1);
         open_in   = 1'b0;
         active_in = 1'b1;
      end else if (active_ff) begin
         if (done) begin
            active_in  = 1'b0;
            open_in    = 1'b0;
            burst.load = 1'b1;
            burst.kind = fcsr_pkg::KIND_END;
         end else if (in_circle || !open_ff) begin
            if (in_circle) begin
               burst.load = 1'b1;
               burst.kind = open_ff ? fcsr_pkg::KIND_PIXEL : fcsr_pkg::KIND_PAGE;
               open_in    = 1'b1;
            end
            if (col_last) begin
               col_in = col_start;
               row_in = row_next;
            end else begin
               col_in = col_ff + COORD_WIDTH'(1);
            end
         end else begin
            // first outside cell after a span: close it and drop to the next row
            open_in = 1'b0;
            col_in  = col_start;
            row_in  = row_next;
         end
      end

      burst.load = burst.load && take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         open_ff   <= 1'b0;
         active_ff <= 1'b0;
      end else if (take) begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         open_ff   <= open_in;
         active_ff <= active_in;
      end
   end

endmodule

FILE: src/fcsr_emitter.sv
// Output word sequencer: holds one tick's burst and plays it out one beat at a time.
// Depends on fcsr_pkg for the burst struct and word kinds.
module fcsr_emitter (
   input  logic                             clock,
   input  logic                             reset,
   input  fcsr_pkg::burst_type              burst,
   output logic                             space,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fcsr_pkg::KINDW-1:0]       rsp_word_kind,
   output logic [fcsr_pkg::VALW-1:0]        rsp_first_value,
   output logic [fcsr_pkg::YW-1:0]          rsp_second_value,
   output logic [fcsr_pkg::DISPW-1:0]       rsp_target_display,
   output logic                             rsp_last_of_run
);

   logic                valid_ff, valid_in;
   fcsr_pkg::burst_type word_ff, word_in;
   logic                last;
   logic                beat;

   assign last  = (word_ff.kind == fcsr_pkg::KIND_PIXEL) || (word_ff.kind == fcsr_pkg::KIND_END);
   assign beat  = valid_ff && rsp_ready;
   assign space = !valid_ff || (rsp_ready && last);

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (burst.load) begin
         valid_in = 1'b1;
         word_in  = burst;
      end else if (beat) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            word_in.kind = word_ff.kind + fcsr_pkg::KINDW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   always_comb begin
      rsp_first_value  = '0;
      rsp_second_value = '0;
      case (word_ff.kind)
         fcsr_pkg::KIND_PAGE: begin
            rsp_first_value  = word_ff.row;
            rsp_second_value = word_ff.y_end;
         end
         fcsr_pkg::KIND_COLUMN: begin
            rsp_first_value  = word_ff.col;
            rsp_second_value = {1'b0, word_ff.x_end};
         end
         fcsr_pkg::KIND_CMD: begin
            rsp_first_value = fcsr_pkg::CMD_MEM_WRITE;
         end
         fcsr_pkg::KIND_PIXEL: begin
            rsp_first_value = word_ff.color;
         end
         default: begin
            rsp_first_value  = '0;
            rsp_second_value = '0;
         end
      endcase
   end

   assign rsp_valid          = valid_ff;
   assign rsp_word_kind      = word_ff.kind;
   assign rsp_target_display = word_ff.disp;
   assign rsp_last_of_run    = last;

endmodule

FILE: src/filled_circle_span_raster.sv
// Top level of the filled-circle span rasterizer: config registers, walker, emitter.
// Depends on fcsr_pkg, fcsr_walker, fcsr_inside and fcsr_emitter.
//
// Each request beat is one tick of the walk over the box interior: a start beat
// resets the walk, every other beat of an active walk visits one cell or ends it.
// The circle test (three squares, a sum and a compare) is combinational, between
// the walk registers and the output word register. Ticks that emit nothing or one
// word (pixel or end) go back to back at one per cycle; a tick that opens a span
// emits four words (set page, set column, 0x2c, pixel), and the emitter holds the
// request side for the three extra beats that it needs to play them out. The
// request side is also held whenever the response side stalls on the last word.
module filled_circle_span_raster #(
   parameter int COORD_WIDTH = 9
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_start_req,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fcsr_pkg::KINDW-1:0]       rsp_word_kind,
   output logic [fcsr_pkg::VALW-1:0]        rsp_first_value,
   output logic [fcsr_pkg::YW-1:0]          rsp_second_value,
   output logic [fcsr_pkg::DISPW-1:0]       rsp_target_display,
   output logic                             rsp_last_of_run,
   // register write port
   input  logic                             csr_wr_en,
   input  logic [fcsr_pkg::IDXW-1:0]        csr_index,
   input  logic [fcsr_pkg::VALW-1:0]        csr_wdata
);

   fcsr_pkg::cfg_type   cfg_ff, cfg_in;
   fcsr_pkg::burst_type burst;
   logic                space;
   logic                take;

   // config writes: drop writes to indexes beyond the register list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            fcsr_pkg::REG_X_BEGIN: cfg_in.x_begin        = csr_wdata[fcsr_pkg::XW-1:0];
            fcsr_pkg::REG_X_END:   cfg_in.x_end          = csr_wdata[fcsr_pkg::XW-1:0];
            fcsr_pkg::REG_Y_BEGIN: cfg_in.y_begin        = csr_wdata[fcsr_pkg::YW-1:0];
            fcsr_pkg::REG_Y_END:   cfg_in.y_end          = csr_wdata[fcsr_pkg::YW-1:0];
            fcsr_pkg::REG_COLOR:   cfg_in.fill_color     = csr_wdata[fcsr_pkg::COLORW-1:0];
            fcsr_pkg::REG_DISPLAY: cfg_in.display_select = csr_wdata[fcsr_pkg::DISPW-1:0];
            default:               cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // take a tick whenever the word register is free or frees up this cycle
   assign req_ready = space;
   assign take      = req_valid && space;

   fcsr_walker #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_walker (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .take     (take),
      .start_req(req_start_req),
      .burst    (burst)
   );

   fcsr_emitter u_emitter (
      .clock             (clock),
      .reset             (reset),
      .burst             (burst),
      .space             (space),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_word_kind     (rsp_word_kind),
      .rsp_first_value   (rsp_first_value),
      .rsp_second_value  (rsp_second_value),
      .rsp_target_display(rsp_target_display),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for filled_circle_span_raster: directed table, then random boxes.
// Depends on fcsr_pkg and the filled_circle_span_raster RTL.
module tb;

   localparam int CW          = 9;       // walk coordinate width
   localparam int SETTLE      = 12;      // cycles for a wordless tick to leave the pipe
   localparam int HOLD_CYCLES = 150;     // long receiver hold-off
   localparam int LIMIT       = 200000;  // watchdog, in clock cycles
   localparam int PLAN_ROWS   = 38;

   // one output word, as seen on the rsp_ ports
   typedef struct packed {
      logic [fcsr_pkg::KINDW-1:0] kind;
      logic [fcsr_pkg::VALW-1:0]  value;
      logic [fcsr_pkg::YW-1:0]    bound;
      logic [fcsr_pkg::DISPW-1:0] disp;
      logic                       tail;
   } span_word_type;

   // directed table rows: a predicted tick, a tick with a typed-in outcome
   // (no words, or one end word), or a register write
   typedef enum logic [1:0] {OP_TICK, OP_QUIET, OP_END, OP_CFG} plan_op_type;

   typedef struct packed {
      plan_op_type                op;
      logic                       start;
      logic [fcsr_pkg::IDXW-1:0]  idx;
      logic [fcsr_pkg::VALW-1:0]  val;
   } plan_row_type;

   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // reset box is empty: idle tick, start, end word, idle again
      '{OP_QUIET, 1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_QUIET, 1'b1, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_END,   1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_QUIET, 1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      // radius 3 circle, centre (13,23); first interior cell already inside
      '{OP_CFG,   1'b0, fcsr_pkg::REG_X_BEGIN, 16'd10},
      '{OP_CFG,   1'b0, fcsr_pkg::REG_X_END,   16'd18},
      '{OP_CFG,   1'b0, fcsr_pkg::REG_Y_BEGIN, 16'd20},
      '{OP_CFG,   1'b0, fcsr_pkg::REG_Y_END,   16'd30},
      '{OP_CFG,   1'b0, fcsr_pkg::REG_COLOR,   16'hffff},
      '{OP_CFG,   1'b0, fcsr_pkg::REG_DISPLAY, 16'd3},
      '{OP_TICK,  1'b1, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      // shrink the box mid-walk: column lands beyond the box, then walk ends
      '{OP_CFG,   1'b0, fcsr_pkg::REG_X_END,   16'd12},
      '{OP_CFG,   1'b0, fcsr_pkg::REG_Y_END,   16'd24},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      // widest and tallest box
      '{OP_CFG,   1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_CFG,   1'b0, fcsr_pkg::REG_X_END,   16'd240},
      '{OP_CFG,   1'b0, fcsr_pkg::REG_Y_BEGIN, 16'd0},
      '{OP_CFG,   1'b0, fcsr_pkg::REG_Y_END,   16'd320},
      '{OP_CFG,   1'b0, fcsr_pkg::REG_COLOR,   16'd0},
      '{OP_CFG,   1'b0, fcsr_pkg::REG_DISPLAY, 16'd0},
      '{OP_TICK,  1'b1, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_TICK,  1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0},
      // zero-width box at the far corner: start, then straight to the end word
      '{OP_CFG,   1'b0, fcsr_pkg::REG_X_BEGIN, 16'd240},
      '{OP_CFG,   1'b0, fcsr_pkg::REG_Y_BEGIN, 16'd320},
      '{OP_QUIET, 1'b1, fcsr_pkg::REG_X_BEGIN, 16'd0},
      '{OP_END,   1'b0, fcsr_pkg::REG_X_BEGIN, 16'd0}
   };

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_start_req;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [fcsr_pkg::KINDW-1:0] rsp_word_kind;
   logic [fcsr_pkg::VALW-1:0]  rsp_first_value;
   logic [fcsr_pkg::YW-1:0]    rsp_second_value;
   logic [fcsr_pkg::DISPW-1:0] rsp_target_display;
   logic                       rsp_last_of_run;
   logic                       csr_wr_en;
   logic [fcsr_pkg::IDXW-1:0]  csr_index;
   logic [fcsr_pkg::VALW-1:0]  csr_wdata;

   // predictor copy of the registers and the walk
   fcsr_pkg::cfg_type          box;
   logic [CW-1:0]              col_pos;
   logic [CW-1:0]              row_pos;
   bit                         span_open;
   bit                         walk_on;

   span_word_type    fresh_words[$];    // words of the tick just predicted
   span_word_type    pending_words[$];  // words still due on the rsp_ side
   plan_op_type      beat_op;           // how the beat on offer is to be checked
   int               send_idle_pct;
   int               recv_idle_pct;
   bit               hold_pending;
   int               error_count;
   int               cycle_count;

   filled_circle_span_raster uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_req      (req_start_req),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_word_kind      (rsp_word_kind),
      .rsp_first_value    (rsp_first_value),
      .rsp_second_value   (rsp_second_value),
      .rsp_target_display (rsp_target_display),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // circle test: squared distance to the centre against the squared radius;
   // a narrow box or a column past the right edge is never in the circle
   function automatic bit cell_in_circle(input int col, input int row);
      int xb, xe, r, dx, dy;
      xb = box.x_begin;
      xe = box.x_end;
      if (xe < xb + 2 || col >= xe)
         return 1'b0;
      r  = (xe - xb) / 2 - 1;
      dx = col - (xb + r);
      dy = row - (int'(box.y_begin) + r);
      return (dx * dx + dy * dy) <= r * r;
   endfunction

   function automatic void emit_word(input logic [fcsr_pkg::KINDW-1:0] kind,
                                     input logic [fcsr_pkg::VALW-1:0] value,
                                     input logic [fcsr_pkg::YW-1:0] bound);
      span_word_type w;
      w.kind  = kind;
      w.value = value;
      w.bound = bound;
      w.disp  = box.display_select;
      w.tail  = 1'b0;
      fresh_words.push_back(w);
   endfunction

   // wrap to the first interior column of the next row
   function automatic void advance_row();
      col_pos = box.x_begin + 9'd1;
      row_pos = row_pos + 9'd1;
   endfunction

   // advance the walk by one beat and leave its words in fresh_words
   function automatic void raster_tick(input logic start);
      bit hit;
      fresh_words.delete();
      if (start) begin
         col_pos = box.x_begin + 9'd1;
         if (int'(box.x_end) < int'(box.x_begin) + 2 ||
             int'(box.y_end) <= int'(box.y_begin) + 1)
            row_pos = box.y_end;  // nothing to draw: next tick ends the walk
         else
            row_pos = box.y_begin + 9'd1;
         span_open = 1'b0;
         walk_on   = 1'b1;
         return;
      end
      if (!walk_on)
         return;
      if (row_pos >= box.y_end) begin
         walk_on   = 1'b0;
         span_open = 1'b0;
         emit_word(fcsr_pkg::KIND_END, '0, '0);
         return;
      end
      hit = cell_in_circle(col_pos, row_pos);
      if (hit) begin
         if (!span_open) begin
            emit_word(fcsr_pkg::KIND_PAGE, 16'(row_pos), box.y_end);
            emit_word(fcsr_pkg::KIND_COLUMN, 16'(col_pos), 9'(box.x_end));
            emit_word(fcsr_pkg::KIND_CMD, fcsr_pkg::CMD_MEM_WRITE, '0);
            span_open = 1'b1;
         end
         emit_word(fcsr_pkg::KIND_PIXEL, box.fill_color, '0);
      end else if (span_open) begin
         // first cell past the span: close it and skip the rest of the row
         span_open = 1'b0;
         advance_row();
         return;
      end
      if (int'(col_pos) + 1 >= int'(box.x_end))
         advance_row();
      else
         col_pos = col_pos + 9'd1;
   endfunction

   function automatic void report_mismatch(input string what, input span_word_type want,
                                           input span_word_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("%s: expected kind %0d value 0x%0h bound %0d disp %0d last %0b",
                  what, want.kind, want.value, want.bound, want.disp, want.tail);
         $display("%s: got      kind %0d value 0x%0h bound %0d disp %0d last %0b",
                  what, got.kind, got.value, got.bound, got.disp, got.tail);
      end
   endfunction

   // ---------------------------------------------------------------- monitor

   // sample both channels and the write port at the rising edge
   always @(posedge clock) begin
      span_word_type got, want;
      if (reset) begin
         box       = '0;
         col_pos   = '0;
         row_pos   = '0;
         span_open = 1'b0;
         walk_on   = 1'b0;
         pending_words.delete();
      end else begin
         cycle_count++;
         if (req_valid && req_ready) begin
            raster_tick(req_start_req);
            case (beat_op)
               OP_QUIET: ;  // typed in: no word due
               OP_END: begin
                  want.kind  = fcsr_pkg::KIND_END;
                  want.value = '0;
                  want.bound = '0;
                  want.disp  = box.display_select;
                  want.tail  = 1'b1;
                  pending_words.push_back(want);
               end
               default: begin
                  foreach (fresh_words[i]) begin
                     want      = fresh_words[i];
                     want.tail = (i == fresh_words.size() - 1);
                     pending_words.push_back(want);
                  end
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got.kind  = rsp_word_kind;
            got.value = rsp_first_value;
            got.bound = rsp_second_value;
            got.disp  = rsp_target_display;
            got.tail  = rsp_last_of_run;
            if (pending_words.size() == 0) begin
               report_mismatch("unexpected word", '0, got);
            end else begin
               want = pending_words.pop_front();
               if (got.kind !== want.kind || got.value !== want.value ||
                   got.bound !== want.bound || got.disp !== want.disp ||
                   got.tail !== want.tail)
                  report_mismatch("word mismatch", want, got);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               fcsr_pkg::REG_X_BEGIN: box.x_begin = csr_wdata[fcsr_pkg::XW-1:0];
               fcsr_pkg::REG_X_END:   box.x_end   = csr_wdata[fcsr_pkg::XW-1:0];
               fcsr_pkg::REG_Y_BEGIN: box.y_begin = csr_wdata[fcsr_pkg::YW-1:0];
               fcsr_pkg::REG_Y_END:   box.y_end   = csr_wdata[fcsr_pkg::YW-1:0];
               fcsr_pkg::REG_COLOR:   box.fill_color = csr_wdata[fcsr_pkg::COLORW-1:0];
               fcsr_pkg::REG_DISPLAY: box.display_select = csr_wdata[fcsr_pkg::DISPW-1:0];
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // stall at random; on request drop ready for a long stretch to back up the block
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready    = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin
      wait (cycle_count >= LIMIT);
      $display("filled_circle_span_raster regression: fail");
      $finish;
   end

   // ---------------------------------------------------------------- sender

   // offer one beat from a falling edge; hold it until accepted, return on the next fall
   task automatic send_tick(input plan_op_type op, input logic start);
      csr_wr_en = 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      beat_op       = op;
      req_start_req = start;
      req_valid     = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // leave csr_wr_en high; the caller drops it after the last write
   task automatic write_reg(input logic [fcsr_pkg::IDXW-1:0] idx, input int val);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val[fcsr_pkg::VALW-1:0];
      @(negedge clock);
   endtask

   // stop offering, wait for every due word, then let wordless ticks retire
   task automatic drain();
      req_valid = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // mostly small boxes so walks finish; sometimes corners of the ranges
   task automatic pick_box(input bit productive);
      int xb, xe, yb, ye;
      if (productive) begin
         xb = $urandom_range(0, 200);
         xe = xb + 10;
         yb = $urandom_range(0, 300);
         ye = yb + 8;
      end else if ($urandom_range(0, 7) == 0) begin
         xb = $urandom_range(0, 1) * 240;
         xe = ($urandom_range(0, 1) == 0) ? xb : 240;
         yb = $urandom_range(0, 1) * 320;
         ye = $urandom_range(0, 1) * 320;
      end else begin
         xb = $urandom_range(0, 228);
         xe = xb + $urandom_range(0, 12);
         yb = $urandom_range(0, 316);
         if ($urandom_range(0, 9) == 0)
            ye = $urandom_range(0, yb);  // bottom above top
         else
            ye = yb + $urandom_range(0, 6);
         if (ye > 320)
            ye = 320;
      end
      write_reg(fcsr_pkg::REG_X_BEGIN, xb);
      write_reg(fcsr_pkg::REG_X_END, xe);
      write_reg(fcsr_pkg::REG_Y_BEGIN, yb);
      write_reg(fcsr_pkg::REG_Y_END, ye);
      write_reg(fcsr_pkg::REG_COLOR, $urandom_range(0, 65535));
      write_reg(fcsr_pkg::REG_DISPLAY, $urandom_range(0, 3));
      csr_wr_en = 1'b0;
   endtask

   // ---------------------------------------------------------------- main

   initial begin
      int   sent, len;
      bit   busy, pressure;
      logic start;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_start_req = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      beat_op       = OP_TICK;
      hold_pending  = 1'b0;
      error_count   = 0;
      cycle_count   = 0;
      send_idle_pct = 7;
      recv_idle_pct = 74;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // walk the directed table; drain before each batch of writes
      busy = 1'b0;
      for (int i = 0; i < PLAN_ROWS; i++) begin
         if (PLAN[i].op == OP_CFG) begin
            if (busy) begin
               drain();
               busy = 1'b0;
            end
            write_reg(PLAN[i].idx, PLAN[i].val);
         end else begin
            send_tick(PLAN[i].op, PLAN[i].start);
            busy = 1'b1;
         end
      end

      // random walks in three idling regimes: sender light, receiver light, none
      for (int regime = 0; regime < 3; regime++) begin
         send_idle_pct = (regime == 0) ? 7 : (regime == 1) ? 74 : 0;
         recv_idle_pct = (regime == 0) ? 74 : (regime == 1) ? 7 : 0;
         sent = 0;
         while (sent < 40) begin
            // first phase without idling backs the block up behind a long hold
            pressure = (regime == 2 && sent == 0);
            drain();
            pick_box(pressure);
            if (pressure)
               hold_pending = 1'b1;
            len = pressure ? 40 : $urandom_range(8, 24);
            for (int k = 0; k < len; k++) begin
               if (pressure)
                  start = (k == 0);
               else if (k == 0)
                  start = ($urandom_range(0, 9) < 8);
               else
                  start = ($urandom_range(0, 39) == 0);
               sent++;
               send_tick(OP_TICK, start);
            end
         end
      end

      req_valid = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0 && pending_words.size() == 0)
         $display("filled_circle_span_raster regression: pass");
      else
         $display("filled_circle_span_raster regression: fail");
      $finish;
   end

endmodule
